// File: sv/mlt_pkg.sv
// Shared types, constants and helpers for the MAC learning table.
`default_nettype none
package mlt_pkg;

    localparam int BUCKETS = 1024;
    localparam int WAYS = 4;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BKT_W = $clog2(BUCKETS);

    localparam int FUNC_W = 2;
    localparam int MAC_W = 48;
    localparam int IP_W = 32;
    localparam int PORT_W = 16;
    localparam int TIME_W = 32;
    localparam int TTL_W = 16;
    localparam int STAT_W = 3;
    localparam int CNT_W = 13;
    localparam int CNT_MAX = 8191;
    localparam int TTL_RESET = 60;

    // byte sum of a MAC is at most 6*255
    localparam int SUM_W = 11;
    localparam int RECIP_SH = 22;
    localparam int RECIP = (1 << RECIP_SH) / BUCKETS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LEARN  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SWEEP  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_HIT     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISS    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NEW     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_REFRESH = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_SWEEP   = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MAC_W-1:0]  mac_address;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_port;
        logic [TIME_W-1:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IP_W-1:0]   found_ip;
        logic [PORT_W-1:0] found_port;
        logic [CNT_W-1:0]  removed_count;
    } res_t;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

    typedef struct packed {
        logic match;
        logic free;
        logic expired;
    } cmp_t;

    function automatic logic [SUM_W-1:0] byte_sum(input logic [MAC_W-1:0] mac);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < 6; b++)
        begin
            acc = acc + SUM_W'(mac[8*b +: 8]);
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

// File: sv/mlt_if.sv
// Request and response word channels of the MAC learning table.
`default_nettype none
interface mlt_req_if
    import mlt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [MAC_W-1:0]  mac_address;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, func, mac_address, dest_ip, dest_port, now_seconds,
                    input ready);
    modport sink (input valid, func, mac_address, dest_ip, dest_port, now_seconds,
                  output ready);
endinterface

interface mlt_rsp_if
    import mlt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IP_W-1:0]   found_ip;
    logic [PORT_W-1:0] found_port;
    logic [CNT_W-1:0]  removed_count;

    modport source (output valid, status, found_ip, found_port, removed_count,
                    input ready);
    modport sink (input valid, status, found_ip, found_port, removed_count,
                  output ready);
endinterface
`default_nettype wire

// File: sv/mac_learning_table_with_aging_unit.sv
// MAC learning table with aging: top level, APB register and response register.
// Lookup: hash, then each way read and checked in turn; a learn that stores adds a write.
// An item walks the ways one at a time through the single table read port; a match stops it.
// Age sweep: every entry is read and checked in turn, and expired entries are cleared.
// After reset a clearing pass writes all BUCKETS*WAYS entries (4096); req.ready stays low.
// Next request accepted once the response sits in the output register.
`default_nettype none
module mac_learning_table_with_aging_unit
    import mlt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    mlt_req_if.sink          req,
    mlt_rsp_if.source        rsp
);

    localparam logic REG_TTL = 1'b0;

    logic [TTL_W-1:0]  ttl_reg;
    logic              out_valid_reg;
    res_t              out_data_reg;
    req_t              in_word;
    res_t              res;
    logic              res_valid;
    logic              res_taken;
    tbl_wr_t           wr;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            rd_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TTL) ? {16'b0, ttl_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= TTL_W'(TTL_RESET);
        end
        else if (psel && penable && pwrite && paddr[2] == REG_TTL)
        begin
            ttl_reg <= pwdata[TTL_W-1:0];
        end
    end

    always_comb
    begin
        in_word.func = req.func;
        in_word.mac_address = req.mac_address;
        in_word.dest_ip = req.dest_ip;
        in_word.dest_port = req.dest_port;
        in_word.now_seconds = req.now_seconds;
        res_taken = res_valid && (!out_valid_reg || rsp.ready);
    end

    mlt_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_word   (in_word),
        .ttl       (ttl_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_taken (res_taken),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_data_reg.status;
    assign rsp.found_ip = out_data_reg.found_ip;
    assign rsp.found_port = out_data_reg.found_port;
    assign rsp.removed_count = out_data_reg.removed_count;

endmodule
`default_nettype wire

// File: sv/mlt_table.sv
// Entry memory: one write port, one registered read port.
`default_nettype none
module mlt_table
    import mlt_pkg::*;
(
    input  wire logic              clk,
    input  wire tbl_wr_t           wr,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/mlt_entry_cmp.sv
// Shared entry compare unit: MAC match, free way and age check.
`default_nettype none
module mlt_entry_cmp
    import mlt_pkg::*;
(
    input  wire entry_t            entry,
    input  wire logic [MAC_W-1:0]  mac,
    input  wire logic [TIME_W-1:0] now,
    input  wire logic [TTL_W-1:0]  ttl,
    output cmp_t                   res
);

    logic [TIME_W:0] limit;

    always_comb
    begin
        limit = {1'b0, entry.stamp} + (TIME_W+1)'(ttl);
        res.match = entry.valid && (entry.mac == mac);
        res.free = !entry.valid;
        res.expired = entry.valid && (limit < {1'b0, now});
    end

endmodule
`default_nettype wire

// File: sv/mlt_ctrl.sv
// Sequencer: hash, way scan, learn write, age sweep and clearing pass.
`default_nettype none
module mlt_ctrl
    import mlt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire req_t              in_word,
    input  wire logic [TTL_W-1:0]  ttl,
    output logic                   res_valid,
    output res_t                   res,
    input  wire logic              res_taken,
    output tbl_wr_t                wr,
    output logic [SLOT_W-1:0]      rd_addr,
    input  wire entry_t            rd_data
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HQ    = 4'd2;
    localparam logic [3:0] S_HR    = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_CK    = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic [STAT_W-1:0] status_reg, status_next;

    req_t              req_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  q_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [IP_W-1:0]   fip_reg;
    logic [PORT_W-1:0] fport_reg;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  rem;
    logic [SLOT_W-1:0] way_slot;
    logic              way_last;
    logic              slot_last;
    logic              sweep;
    cmp_t              cmp;

    mlt_entry_cmp u_cmp (
        .entry (rd_data),
        .mac   (req_reg.mac_address),
        .now   (req_reg.now_seconds),
        .ttl   (ttl),
        .res   (cmp)
    );

    always_comb
    begin
        prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
        rem = sum_reg - SUM_W'(PROD_W'(q_reg) * PROD_W'(BUCKETS));
        way_slot = SLOT_W'(bucket_reg) * SLOT_W'(WAYS) + SLOT_W'(way_reg);
        way_last = (way_reg == WAY_W'(WAYS - 1));
        slot_last = (slot_reg == SLOT_W'(SLOTS - 1));
        sweep = (req_reg.func == FN_SWEEP);
        rd_addr = sweep ? slot_reg : way_slot;
        in_ready = (state_reg == S_IDLE);
        res_valid = (state_reg == S_RESP);
        res.status = status_reg;
        res.found_ip = fip_reg;
        res.found_port = fport_reg;
        res.removed_count = removed_reg;
    end

    // write port
    always_comb
    begin
        wr.en = 1'b0;
        wr.addr = slot_reg;
        wr.data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en = 1'b1;
            end
            S_WR:
            begin
                wr.en = 1'b1;
                wr.addr = wr_slot_reg;
                wr.data.valid = 1'b1;
                wr.data.mac = req_reg.mac_address;
                wr.data.ip = req_reg.dest_ip;
                wr.data.port = req_reg.dest_port;
                wr.data.stamp = req_reg.now_seconds;
            end
            S_CK:
            begin
                wr.en = sweep && cmp.expired;
                wr.data = rd_data;
                wr.data.valid = 1'b0;
            end
            default:
            begin
                wr.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next = slot_reg;
        way_next = way_reg;
        free_found_next = free_found_reg;
        free_slot_next = free_slot_reg;
        wr_slot_next = wr_slot_reg;
        removed_next = removed_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_next = slot_reg + SLOT_W'(1);
                if (slot_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    slot_next = '0;
                    way_next = '0;
                    free_found_next = 1'b0;
                    removed_next = '0;
                    status_next = STAT_MISS;
                    unique case (in_word.func)
                        FN_LOOKUP, FN_LEARN: state_next = S_HQ;
                        FN_SWEEP:
                        begin
                            status_next = STAT_SWEEP;
                            state_next = S_RD;
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_HQ:
            begin
                state_next = S_HR;
            end
            S_HR:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_CK;
            end
            S_CK:
            begin
                if (sweep)
                begin
                    if (cmp.expired && (removed_reg != CNT_W'(CNT_MAX)))
                    begin
                        removed_next = removed_reg + CNT_W'(1);
                    end
                    slot_next = slot_reg + SLOT_W'(1);
                    state_next = slot_last ? S_RESP : S_RD;
                end
                else if (cmp.match)
                begin
                    if (req_reg.func == FN_LOOKUP)
                    begin
                        status_next = STAT_HIT;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        status_next = STAT_REFRESH;
                        wr_slot_next = way_slot;
                        state_next = S_WR;
                    end
                end
                else
                begin
                    if (cmp.free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next = way_slot;
                    end
                    if (!way_last)
                    begin
                        way_next = way_reg + WAY_W'(1);
                        state_next = S_RD;
                    end
                    else if (req_reg.func == FN_LOOKUP)
                    begin
                        status_next = STAT_MISS;
                        state_next = S_RESP;
                    end
                    else if (free_found_reg)
                    begin
                        status_next = STAT_NEW;
                        wr_slot_next = free_slot_reg;
                        state_next = S_WR;
                    end
                    else if (cmp.free)
                    begin
                        status_next = STAT_NEW;
                        wr_slot_next = way_slot;
                        state_next = S_WR;
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                        state_next = S_RESP;
                    end
                end
            end
            S_WR:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            slot_reg <= '0;
            way_reg <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg <= '0;
            wr_slot_reg <= '0;
            removed_reg <= '0;
            status_reg <= STAT_MISS;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            way_reg <= way_next;
            free_found_reg <= free_found_next;
            free_slot_reg <= free_slot_next;
            wr_slot_reg <= wr_slot_next;
            removed_reg <= removed_next;
            status_reg <= status_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg <= in_word;
            sum_reg <= byte_sum(in_word.mac_address);
            fip_reg <= '0;
            fport_reg <= '0;
        end
        if (state_reg == S_HQ)
        begin
            q_reg <= SUM_W'(prod >> RECIP_SH);
        end
        if (state_reg == S_HR)
        begin
            if (PROD_W'(rem) >= PROD_W'(BUCKETS))
            begin
                bucket_reg <= BKT_W'(PROD_W'(rem) - PROD_W'(BUCKETS));
            end
            else
            begin
                bucket_reg <= BKT_W'(rem);
            end
        end
        if (state_reg == S_CK && !sweep && cmp.match && req_reg.func == FN_LOOKUP)
        begin
            fip_reg <= rd_data.ip;
            fport_reg <= rd_data.port;
        end
    end

endmodule
`default_nettype wire

// File: sv/mlt_checker.sv
// Port-level checks for the MAC learning table, bound to the top level.
`default_nettype none
module mlt_checker
    import mlt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [STAT_W-1:0] rsp_status,
    input wire logic [IP_W-1:0]   rsp_found_ip,
    input wire logic [PORT_W-1:0] rsp_found_port,
    input wire logic [CNT_W-1:0]  rsp_removed_count
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a word is in progress");

    a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STAT_HIT |-> rsp_found_ip == '0 && rsp_found_port == '0)
        else $error("destination data on a non-hit response");

    a_count_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STAT_SWEEP |-> rsp_removed_count == '0)
        else $error("removed count on a non-sweep response");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_removed_count))
        else $error("stalled response word changed");

endmodule

bind mac_learning_table_with_aging_unit mlt_checker u_mlt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_found_ip      (rsp.found_ip),
    .rsp_found_port    (rsp.found_port),
    .rsp_removed_count (rsp.removed_count)
);
`default_nettype wire

// File: sim/tb_mac_learning_table_with_aging_unit.sv
// Self-checking testbench for the MAC learning table: predicted lookups, learns and age sweeps.
module tb_mac_learning_table_with_aging_unit
    import mlt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam logic [2:0] TTL_ADDR = 3'd0;
    localparam int unsigned STALL_LIMIT = 40000;
    localparam int unsigned PRESSURE_HOLD = 400;
    localparam int unsigned PHASE_WORDS = 367;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    mlt_req_if req();
    mlt_rsp_if rsp();

    mac_learning_table_with_aging_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req(req),
        .rsp(rsp)
    );

    always #2 clk = ~clk;

    // shadow of the table and the ttl register
    logic tbl_valid [SLOTS];
    logic [MAC_W-1:0] tbl_mac [SLOTS];
    logic [IP_W-1:0] tbl_ip [SLOTS];
    logic [PORT_W-1:0] tbl_port [SLOTS];
    logic [TIME_W-1:0] tbl_stamp [SLOTS];
    logic [TTL_W-1:0] ttl_now;

    req_t requests_pending [$];
    res_t answers_due [$];
    req_t offer;
    logic [TIME_W-1:0] clock_now;

    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    logic calm_tail = 1'b0;
    logic pressure_armed = 1'b0;
    logic pressure_taken = 1'b0;

    function automatic int unsigned mac_bucket(logic [MAC_W-1:0] m);
        int unsigned total;
        total = 0;
        for (int k = 0; k < 6; k++)
        begin
            total += m[8*k +: 8];
        end
        return total % BUCKETS;
    endfunction

    // random MAC whose byte sum is exactly total (0..1530)
    function automatic logic [MAC_W-1:0] mac_with_sum(int unsigned total);
        logic [MAC_W-1:0] m;
        int unsigned left;
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        left = total;
        m = '0;
        for (int k = 0; k < 6; k++)
        begin
            hi = (left < 255) ? left : 255;
            lo = (left > 255 * (5 - k)) ? left - 255 * (5 - k) : 0;
            v = $urandom_range(hi, lo);
            m[8*k +: 8] = v[7:0];
            left -= v;
        end
        return m;
    endfunction

    // applies one request word to the shadow table and returns the expected response
    function automatic res_t table_answer(req_t r);
        res_t a;
        int unsigned base;
        int hit;
        int unsigned removed;
        a = '0;
        a.status = STAT_MISS;
        base = mac_bucket(r.mac_address) * WAYS;
        hit = -1;
        removed = 0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit < 0 && tbl_valid[base + w] && tbl_mac[base + w] == r.mac_address)
                hit = base + w;
        end
        case (r.func)
            FN_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    a.status = STAT_HIT;
                    a.found_ip = tbl_ip[hit];
                    a.found_port = tbl_port[hit];
                end
            end
            FN_LEARN:
            begin
                if (hit >= 0)
                begin
                    tbl_ip[hit] = r.dest_ip;
                    tbl_port[hit] = r.dest_port;
                    tbl_stamp[hit] = r.now_seconds;
                    a.status = STAT_REFRESH;
                end
                else
                begin
                    a.status = STAT_FULL;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (a.status == STAT_FULL && !tbl_valid[base + w])
                        begin
                            tbl_valid[base + w] = 1'b1;
                            tbl_mac[base + w] = r.mac_address;
                            tbl_ip[base + w] = r.dest_ip;
                            tbl_port[base + w] = r.dest_port;
                            tbl_stamp[base + w] = r.now_seconds;
                            a.status = STAT_NEW;
                        end
                    end
                end
            end
            FN_SWEEP:
            begin
                a.status = STAT_SWEEP;
                for (int s = 0; s < SLOTS; s++)
                begin
                    // 33-bit compare, no wrap of stamp + ttl
                    if (tbl_valid[s] && ({1'b0, tbl_stamp[s]} + {17'd0, ttl_now})
                                        < {1'b0, r.now_seconds})
                    begin
                        tbl_valid[s] = 1'b0;
                        if (removed < CNT_MAX)
                            removed++;
                    end
                end
                a.removed_count = CNT_W'(removed);
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic flag_mismatch(string what, logic [47:0] got, logic [47:0] want);
        if (mismatches < 50)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_request(logic [FUNC_W-1:0] fn, logic [MAC_W-1:0] mac,
                                 logic [IP_W-1:0] ip, logic [PORT_W-1:0] port,
                                 logic [TIME_W-1:0] stamp);
        req_t r;
        r.func = fn;
        r.mac_address = mac;
        r.dest_ip = ip;
        r.dest_port = port;
        r.now_seconds = stamp;
        requests_pending.push_back(r);
    endtask

    task automatic write_ttl(logic [TTL_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= TTL_ADDR;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ttl_now = value;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (requests_pending.size() != 0 || req.valid || answers_due.size() != 0);
    endtask

    // mostly learns and lookups on a few crowded buckets, plus noise and sweeps
    task automatic churn_phase(int unsigned count);
        logic [MAC_W-1:0] pool [$];
        int unsigned b;
        int unsigned pick;
        logic [FUNC_W-1:0] fn;
        logic [MAC_W-1:0] mac;
        logic [TIME_W-1:0] stamp;
        pool = {};
        repeat (3)
        begin
            b = $urandom_range(0, 505);
            repeat (6)
                pool.push_back(mac_with_sum($urandom_range(0, 1) ? b : b + 1024));
        end
        clock_now = $urandom();
        repeat (count)
        begin
            pick = $urandom_range(0, 199);
            if ($urandom_range(0, 19) == 0)
                clock_now += $urandom_range(0, 100000);
            else
                clock_now += $urandom_range(0, 40);
            mac = pool[$urandom_range(0, pool.size() - 1)];
            stamp = clock_now;
            if (pick < 80)
                fn = FN_LEARN;
            else if (pick < 150)
                fn = FN_LOOKUP;
            else if (pick < 153)
            begin
                fn = FN_SWEEP;
                if ($urandom_range(0, 3) == 0)
                    stamp = $urandom();
            end
            else if (pick < 170)
            begin
                fn = FN_LEARN;
                mac = {16'($urandom()), $urandom()};
            end
            else if (pick < 185)
            begin
                fn = FN_LOOKUP;
                mac = {16'($urandom()), $urandom()};
            end
            else if (pick < 192)
            begin
                fn = FN_UNUSED;
                mac = {16'($urandom()), $urandom()};
                stamp = $urandom();
            end
            else
            begin
                fn = FN_LEARN;
                stamp = $urandom();
            end
            queue_request(fn, mac, $urandom(), 16'($urandom()), stamp);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.func <= '0;
            req.mac_address <= '0;
            req.dest_ip <= '0;
            req.dest_port <= '0;
            req.now_seconds <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                answers_due.push_back(table_answer(offer));
            if (req.valid && !req.ready)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req.valid <= 1'b0;
            end
            else if (requests_pending.size() > 0)
            begin
                offer = requests_pending.pop_front();
                req.func <= offer.func;
                req.mac_address <= offer.mac_address;
                req.dest_ip <= offer.dest_ip;
                req.dest_port <= offer.dest_port;
                req.now_seconds <= offer.now_seconds;
                req.valid <= 1'b1;
                if (!calm_tail && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 10);
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    flag_mismatch("word with nothing due, status", rsp.status, 48'd0);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                        flag_mismatch("status", rsp.status, want.status);
                    if (rsp.found_ip !== want.found_ip)
                        flag_mismatch("found_ip", rsp.found_ip, want.found_ip);
                    if (rsp.found_port !== want.found_port)
                        flag_mismatch("found_port", rsp.found_port, want.found_port);
                    if (rsp.removed_count !== want.removed_count)
                        flag_mismatch("removed_count", rsp.removed_count, want.removed_count);
                end
            end
            if (pressure_armed && !pressure_taken)
            begin
                pressure_taken = 1'b1;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_mac_learning_table_with_aging_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [MAC_W-1:0] crowd [4];
        logic [TTL_W-1:0] ttl_plan [5];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_valid[s] = 1'b0;
        end
        ttl_now = TTL_W'(TTL_RESET);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, refresh, full bucket, unused code, ttl boundary, no-wrap aging
        for (int k = 0; k < 4; k++)
        begin
            crowd[k] = mac_with_sum(506);
        end
        queue_request(FN_LOOKUP, '0, '0, '0, '0);
        queue_request(FN_LEARN, '0, '0, '0, '0);
        queue_request(FN_LOOKUP, '0, '0, '0, '0);
        queue_request(FN_LEARN, '1, '1, '1, '1);
        queue_request(FN_LOOKUP, '1, '0, '0, '0);
        queue_request(FN_LEARN, '1, 32'h1234_5678, 16'hbeef, 32'hffff_fff0);
        for (int k = 0; k < 4; k++)
        begin
            queue_request(FN_LEARN, crowd[k], $urandom(), 16'($urandom()), 32'd1000);
        end
        queue_request(FN_LOOKUP, crowd[3], '0, '0, '0);
        queue_request(FN_LOOKUP, crowd[0], '0, '0, '0);
        queue_request(FN_UNUSED, '1, '1, '1, '1);
        queue_request(FN_SWEEP, '0, '0, '0, 32'd60);
        queue_request(FN_SWEEP, '0, '0, '0, 32'd61);
        queue_request(FN_LOOKUP, '0, '0, '0, '0);
        queue_request(FN_SWEEP, '1, '1, '1, 32'hffff_ffff);
        queue_request(FN_LOOKUP, '1, '0, '0, '0);
        queue_request(FN_LEARN, crowd[3], $urandom(), 16'($urandom()), 32'hffff_ffff);
        wait_drained();

        ttl_plan[0] = '0;
        ttl_plan[1] = '1;
        ttl_plan[2] = TTL_W'($urandom_range(2, 65534));
        ttl_plan[3] = 16'd1;
        ttl_plan[4] = TTL_W'($urandom_range(20, 200));
        for (int p = 0; p < 5; p++)
        begin
            write_ttl(ttl_plan[p]);
            if (p == 1)
                pressure_armed = 1'b1;
            churn_phase(PHASE_WORDS);
            if (p == 4)
            begin
                while (requests_pending.size() > 100)
                    @(negedge clk);
                calm_tail = 1'b1;
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("tb_mac_learning_table_with_aging_unit OK");
        else
            $display("tb_mac_learning_table_with_aging_unit NOT OK");
        $finish;
    end

endmodule
